[src/ogrc_pkg.sv]
// ----------------------------------------------------------------------------
// Occupancy-grid ray caster package
// Grid geometry, CORDIC constants, register indexes and result codes.
// ----------------------------------------------------------------------------
package ogrc_pkg;

  // Grid geometry: the memory holds GRID_SIDE by GRID_SIDE signed 8-bit cells.
  localparam int GRID_SIDE = 1024;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int GRID_AW   = $clog2(CELLS);

  // CORDIC iteration count, never more than the arctangent table holds.
  localparam int ANGLE_ITERATIONS = 16;
  localparam int NUM_ITER         = (ANGLE_ITERATIONS > 24) ? 24 : ANGLE_ITERATIONS;

  // Fixed-point constants.
  localparam logic [19:0]        MIN_STEP      = 20'd3277;
  localparam logic signed [35:0] CORDIC_GAIN   = 36'sd652032874;
  localparam logic signed [32:0] BEARING_SCALE = 33'sd83443;
  localparam logic signed [33:0] HALF_TURN     = 34'sh0_8000_0000;
  localparam logic signed [33:0] QUARTER_TURN  = 34'sh0_4000_0000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MAP_WIDTH    = 3'd0,
    REG_MAP_HEIGHT   = 3'd1,
    REG_CELL_SIZE    = 3'd2,
    REG_INV_CELL     = 3'd3,
    REG_ORIGIN_X     = 3'd4,
    REG_ORIGIN_Y     = 3'd5,
    REG_RANGE_LIMIT  = 3'd6,
    REG_OCC_LEVEL    = 3'd7
  } reg_index_t;

  // Request operations.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_LEFT  = 2'd1,
    ST_RANGE = 2'd2,
    ST_NOMAP = 2'd3
  } status_t;

  // Arctangent table in binary-angle units (2^32 per full turn).
  function automatic logic [31:0] arc_angle(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

[src/occupancy_grid_ray_cast_top.sv]
// ----------------------------------------------------------------------------
// Occupancy-grid ray caster
// Loads an occupancy grid and marches rays from a robot pose through it,
// reporting the first occupied cell.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  in       in_valid / in_stall  op, cell_index, cell_value, robot_x/y,
//                                quat_x/y/z/w, bearing
//  out      out_valid/out_stall  status, hit_column, hit_row, goal_x, goal_y
//  cfg      cfg_write            cfg_index, cfg_data
//
// A write request leaves the block idle, ready for the next request. A cast
// forms the quaternion products, then runs two 16-step CORDIC passes on one
// shared shifter (only the rotation pass when the yaw vector is zero), then
// marches, each step paced by the single shared multiplier and the registered
// grid memory read. Reset is synchronous; the grid is not cleared. A finished
// result waits in the output register while a new request is taken; a cast
// that finishes while that register is still stalled waits for it to drain.
module occupancy_grid_ray_cast_top
  import ogrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Configuration
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // Request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [19:0]        cell_index,
  input  logic signed [7:0]  cell_value,
  input  logic signed [31:0] robot_x,
  input  logic signed [31:0] robot_y,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] bearing,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [9:0]         hit_column,
  output logic [9:0]         hit_row,
  output logic signed [31:0] goal_x,
  output logic signed [31:0] goal_y
);

  typedef enum logic [4:0] {
    S_IDLE, S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_Q5, S_VEC, S_ROT_SET, S_ROT, S_CS,
    S_STEPX, S_STEPY, S_STEPI, S_POS, S_MXH, S_MXL, S_MYH, S_MYL, S_ROWC,
    S_CHK, S_ADDR, S_READ, S_TEST, S_GX, S_GY, S_FINISH
  } state_t;

  state_t state;

  // Configuration registers
  logic [10:0]        map_width, map_height;
  logic [20:0]        cell_size;
  logic [30:0]        inverse_cell_size;
  logic signed [31:0] map_origin_x, map_origin_y;
  logic [24:0]        range_limit;
  logic [6:0]         occupied_level;
  logic               map_loaded;

  // Latched request
  logic signed [31:0] rx, ry;
  logic signed [15:0] qx, qy, qz, qw, brg;

  // Shared multiplier
  logic signed [21:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [54:0] prod;
  logic signed [54:0] acc;

  // Angle work
  logic signed [31:0] sy, cy;
  logic [31:0]        boff;
  logic signed [35:0] x, y;
  logic signed [33:0] z;
  logic [4:0]         it;
  logic               flip;
  logic signed [32:0] cos_v, sin_v;

  // March work
  logic [19:0]        step;
  logic signed [54:0] incx, incy;
  logic signed [59:0] px, py;
  logic [25:0]        travel;
  logic [33:0]        dxr, dyr;
  logic [38:0]        colf, rowf;
  logic [15:0]        w_eff, h_eff;

  // Grid memory
  logic [7:0]         grid [CELLS];
  logic [GRID_AW-1:0] rd_addr;
  logic [7:0]         rdata;

  // Result
  status_t            res_status;
  logic signed [31:0] res_gx, res_gy;

  // Combinational helpers
  logic signed [35:0] sh_x, sh_y;
  logic signed [33:0] atab;
  logic               sub_mode;
  logic signed [54:0] qsum;
  logic [31:0]        theta;
  logic signed [33:0] zs;
  logic signed [35:0] dx_c, dy_c;
  logic [38:0]        cell_c;
  logic               accept, out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Effective map size and march step.
  always_comb begin
    w_eff = ({5'b0, map_width} > 16'(GRID_SIDE)) ? 16'(GRID_SIDE) : {5'b0, map_width};
    h_eff = ({5'b0, map_height} > 16'(GRID_SIDE)) ? 16'(GRID_SIDE) : {5'b0, map_height};
    step  = (cell_size[20:1] < MIN_STEP) ? MIN_STEP : cell_size[20:1];
  end

  // Shared CORDIC shifter and direction.
  always_comb begin
    sh_x     = x >>> it;
    sh_y     = y >>> it;
    atab     = $signed({2'b0, arc_angle(it)});
    sub_mode = (state == S_VEC) ? y[35] : !z[33];
    qsum     = acc + prod;
    theta    = z[31:0] + boff;
    zs       = 34'($signed(theta));
    dx_c     = 36'(rx) + 36'($signed(px[59:30])) - 36'(map_origin_x);
    dy_c     = 36'(ry) + 36'($signed(py[59:30])) - 36'(map_origin_y);
    cell_c   = 39'(($unsigned(acc) + ($unsigned(prod) >> 16)) >> 16);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_Q0: begin
        mul_a = 22'(qw); mul_b = 33'(qz);
      end
      S_Q1: begin
        mul_a = 22'(qx); mul_b = 33'(qy);
      end
      S_Q2: begin
        mul_a = 22'(qy); mul_b = 33'(qy);
      end
      S_Q3: begin
        mul_a = 22'(qz); mul_b = 33'(qz);
      end
      S_Q4: begin
        mul_a = 22'(brg); mul_b = BEARING_SCALE;
      end
      S_STEPX: begin
        mul_a = $signed({2'b0, step}); mul_b = cos_v;
      end
      S_STEPY: begin
        mul_a = $signed({2'b0, step}); mul_b = sin_v;
      end
      S_MXH: begin
        mul_a = $signed({4'b0, dxr[33:16]}); mul_b = $signed({2'b0, inverse_cell_size});
      end
      S_MXL: begin
        mul_a = $signed({6'b0, dxr[15:0]}); mul_b = $signed({2'b0, inverse_cell_size});
      end
      S_MYH: begin
        mul_a = $signed({4'b0, dyr[33:16]}); mul_b = $signed({2'b0, inverse_cell_size});
      end
      S_MYL: begin
        mul_a = $signed({6'b0, dyr[15:0]}); mul_b = $signed({2'b0, inverse_cell_size});
      end
      S_CHK: begin
        mul_a = $signed({1'b0, rowf[20:0]}); mul_b = $signed({17'b0, w_eff});
      end
      S_TEST: begin
        mul_a = $signed({1'b0, colf[20:0]}); mul_b = $signed({12'b0, cell_size});
      end
      S_GX: begin
        mul_a = $signed({1'b0, rowf[20:0]}); mul_b = $signed({12'b0, cell_size});
      end
      default: begin
        mul_a = '0; mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Grid memory: one write port from requests, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && op == OP_WRITE && {1'b0, cell_index} < 21'(CELLS)) begin
      grid[cell_index[GRID_AW-1:0]] <= cell_value;
    end
    rdata <= grid[rd_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width         <= 11'd1024;
      map_height        <= 11'd1024;
      cell_size         <= 21'd3277;
      inverse_cell_size <= 31'd1310720;
      map_origin_x      <= '0;
      map_origin_y      <= '0;
      range_limit       <= 25'd1966080;
      occupied_level    <= 7'd50;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_MAP_WIDTH:   map_width         <= cfg_data[10:0];
        REG_MAP_HEIGHT:  map_height        <= cfg_data[10:0];
        REG_CELL_SIZE:   cell_size         <= cfg_data[20:0];
        REG_INV_CELL:    inverse_cell_size <= cfg_data[30:0];
        REG_ORIGIN_X:    map_origin_x      <= $signed(cfg_data);
        REG_ORIGIN_Y:    map_origin_y      <= $signed(cfg_data);
        REG_RANGE_LIMIT: range_limit       <= cfg_data[24:0];
        REG_OCC_LEVEL:   occupied_level    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer with the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      map_loaded <= 1'b0;
      out_valid  <= 1'b0;
      it         <= '0;
    end else begin
      // The finishing stage reloads the result register itself.
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == OP_WRITE) begin
              map_loaded <= 1'b1;
            end else if (!map_loaded) begin
              res_status <= ST_NOMAP;
              state      <= S_FINISH;
            end else begin
              rx <= robot_x; ry <= robot_y;
              qx <= quat_x; qy <= quat_y; qz <= quat_z; qw <= quat_w;
              brg   <= bearing;
              state <= S_Q0;
            end
          end
        end
        // Yaw vector terms from the quaternion.
        S_Q0: state <= S_Q1;
        S_Q1: begin
          acc   <= prod;
          state <= S_Q2;
        end
        S_Q2: begin
          sy    <= 32'(qsum <<< 1);
          state <= S_Q3;
        end
        S_Q3: begin
          acc   <= prod;
          state <= S_Q4;
        end
        S_Q4: begin
          cy    <= 32'sh1000_0000 - 32'(qsum <<< 1);
          state <= S_Q5;
        end
        S_Q5: begin
          boff <= prod[31:0];
          it   <= '0;
          if (cy == 0 && sy == 0) begin
            z     <= '0;
            state <= S_ROT_SET;
          end else begin
            if (cy < 0) begin
              x <= -36'(cy); y <= -36'(sy); z <= HALF_TURN;
            end else begin
              x <= 36'(cy); y <= 36'(sy); z <= '0;
            end
            state <= S_VEC;
          end
        end
        // Vectoring and rotation share the same shift-and-add step.
        S_VEC, S_ROT: begin
          if (sub_mode) begin
            x <= x - sh_y; y <= y + sh_x; z <= z - atab;
          end else begin
            x <= x + sh_y; y <= y - sh_x; z <= z + atab;
          end
          it <= it + 5'd1;
          if (it == 5'(NUM_ITER - 1)) begin
            state <= (state == S_VEC) ? S_ROT_SET : S_CS;
          end
        end
        // Fold the ray angle into the right half-plane.
        S_ROT_SET: begin
          x    <= CORDIC_GAIN;
          y    <= '0;
          it   <= '0;
          if (zs > QUARTER_TURN) begin
            z <= zs - HALF_TURN; flip <= 1'b1;
          end else if (zs < -QUARTER_TURN) begin
            z <= zs + HALF_TURN; flip <= 1'b1;
          end else begin
            z <= zs; flip <= 1'b0;
          end
          state <= S_ROT;
        end
        S_CS: begin
          cos_v <= 33'(flip ? -x : x);
          sin_v <= 33'(flip ? -y : y);
          state <= S_STEPX;
        end
        // Per-step position increments.
        S_STEPX: state <= S_STEPY;
        S_STEPY: begin
          incx  <= prod;
          state <= S_STEPI;
        end
        S_STEPI: begin
          incy   <= prod;
          travel <= '0;
          px     <= '0;
          py     <= '0;
          state  <= S_POS;
        end
        // March: position of the sample relative to the map corner.
        S_POS: begin
          if (travel > {1'b0, range_limit}) begin
            res_status <= ST_RANGE;
            state      <= S_FINISH;
          end else if (dx_c[35] || dy_c[35]) begin
            res_status <= ST_LEFT;
            state      <= S_FINISH;
          end else begin
            dxr   <= dx_c[33:0];
            dyr   <= dy_c[33:0];
            state <= S_MXH;
          end
        end
        S_MXH: state <= S_MXL;
        S_MXL: begin
          acc   <= prod;
          state <= S_MYH;
        end
        S_MYH: begin
          colf  <= cell_c;
          state <= S_MYL;
        end
        S_MYL: begin
          acc   <= prod;
          state <= S_ROWC;
        end
        S_ROWC: begin
          rowf  <= cell_c;
          state <= S_CHK;
        end
        S_CHK: begin
          if (colf >= {23'b0, w_eff} || rowf >= {23'b0, h_eff}) begin
            res_status <= ST_LEFT;
            state      <= S_FINISH;
          end else begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          rd_addr <= prod[GRID_AW-1:0] + colf[GRID_AW-1:0];
          state   <= S_READ;
        end
        S_READ: state <= S_TEST;
        // Occupancy test, or advance to the next sample.
        S_TEST: begin
          if ($signed(rdata) >= $signed({1'b0, occupied_level})) begin
            state <= S_GX;
          end else begin
            travel <= travel + 26'(step);
            px     <= px + 60'(incx);
            py     <= py + 60'(incy);
            state  <= S_POS;
          end
        end
        // Cell centre of the hit.
        S_GX: begin
          res_gx <= map_origin_x + prod[31:0] + 32'(cell_size[20:1]);
          state  <= S_GY;
        end
        S_GY: begin
          res_gy     <= map_origin_y + prod[31:0] + 32'(cell_size[20:1]);
          res_status <= ST_HIT;
          state      <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            if (res_status == ST_HIT) begin
              hit_column <= colf[9:0];
              hit_row    <= rowf[9:0];
              goal_x     <= res_gx;
              goal_y     <= res_gy;
            end else begin
              hit_column <= '0;
              hit_row    <= '0;
              goal_x     <= '0;
              goal_y     <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Non-hit results carry zero position fields.
  a_zero_on_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_HIT |-> hit_column == 0 && hit_row == 0 &&
    goal_x == 0 && goal_y == 0)
    else $error("non-hit result carries position data");

  // A cast before any grid write goes straight to the result stage.
  a_nomap_fast: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_CAST && !map_loaded |=> state == S_FINISH)
    else $error("cast without map did not finish at once");

  // A new result only appears from the finishing stage.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result appeared outside the finishing stage");
`endif

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Occupancy-grid ray caster testbench
// Loads small maps through write requests, casts rays into them under several
// register settings, and checks every result against an internal predictor
// of the heading CORDIC, the direction CORDIC and the grid march.
// ----------------------------------------------------------------------------
module testbench;
  import ogrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    op_t                op;
    logic [19:0]        cell_index;
    logic signed [7:0]  cell_value;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] bearing;
  } ray_request_t;

  typedef struct {
    status_t     status;
    logic [9:0]  column;
    logic [9:0]  row;
    logic [31:0] goal_x;
    logic [31:0] goal_y;
  } ray_result_t;

  // Arctangent steps in binary-angle units, 2^32 per turn.
  localparam longint ATAN_STEP [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  // Predicts the result of every cast and keeps the results still owed.
  class ray_scoreboard;
    byte               grid[];
    bit                loaded;
    int unsigned       width_cells, height_cells, cell_len, cells_per_m;
    longint            corner_x, corner_y;
    int unsigned       reach_limit, occ_level;
    ray_result_t       owed[$];
    int                errors;

    function new();
      grid = new[CELLS];
      loaded = 0;
      width_cells = 1024;
      height_cells = 1024;
      cell_len = 3277;
      cells_per_m = 1310720;
      corner_x = 0;
      corner_y = 0;
      reach_limit = 1966080;
      occ_level = 50;
      errors = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [31:0] d);
      case (idx)
        REG_MAP_WIDTH:   width_cells = 32'(d[10:0]);
        REG_MAP_HEIGHT:  height_cells = 32'(d[10:0]);
        REG_CELL_SIZE:   cell_len = 32'(d[20:0]);
        REG_INV_CELL:    cells_per_m = 32'(d[30:0]);
        REG_ORIGIN_X:    corner_x = longint'($signed(d));
        REG_ORIGIN_Y:    corner_y = longint'($signed(d));
        REG_RANGE_LIMIT: reach_limit = 32'(d[24:0]);
        REG_OCC_LEVEL:   occ_level = 32'(d[6:0]);
        default: ;
      endcase
    endfunction

    // Vectoring pass: binary angle of (cy, sy).
    function longint heading(longint cy, longint sy);
      longint x, y, z, dx, dy;
      if (cy == 0 && sy == 0) return 0;
      x = cy;
      y = sy;
      z = 0;
      // Vectors in the left half plane are turned round first.
      if (cy < 0) begin
        x = -cy;
        y = -sy;
        z = 64'sh8000_0000;
      end
      for (int i = 0; i < NUM_ITER; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y < 0) begin
          x -= dx; y += dy; z -= ATAN_STEP[i];
        end else begin
          x += dx; y -= dy; z += ATAN_STEP[i];
        end
      end
      return z;
    endfunction

    // Rotation pass: cosine and sine of a binary angle, Q1.30.
    function void direction(logic [31:0] theta, output longint c, output longint s);
      longint x, y, z, dx, dy;
      bit flip;
      z = longint'($signed(theta));
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > 64'sh4000_0000) begin
        z -= 64'sh8000_0000; flip = 1;
      end else if (z < -64'sh4000_0000) begin
        z += 64'sh8000_0000; flip = 1;
      end
      for (int i = 0; i < NUM_ITER; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_STEP[i];
        end else begin
          x += dx; y -= dy; z += ATAN_STEP[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    // Exact floor(d * cells_per_m / 2^32).
    function longint unsigned cell_of(longint unsigned d);
      longint unsigned hi, lo;
      hi = (d >> 16) * cells_per_m;
      lo = (d & 64'hFFFF) * cells_per_m;
      return (hi + (lo >> 16)) >> 16;
    endfunction

    function ray_result_t cast_ray(ray_request_t r);
      ray_result_t res;
      longint sy, cy, c, s, dx, dy, turn;
      longint unsigned travel, col, row;
      logic [63:0] g;
      logic [31:0] theta;
      int unsigned step, w, h;
      byte v;
      res.status = ST_RANGE;
      res.column = '0;
      res.row = '0;
      res.goal_x = '0;
      res.goal_y = '0;
      if (!loaded) begin
        res.status = ST_NOMAP;
        return res;
      end
      sy = 2 * (longint'(r.quat_w) * r.quat_z + longint'(r.quat_x) * r.quat_y);
      cy = (64'sd1 <<< 28) - 2 * (longint'(r.quat_y) * r.quat_y +
                                   longint'(r.quat_z) * r.quat_z);
      turn = heading(cy, sy) + longint'(r.bearing) * 83443;
      theta = turn[31:0];
      direction(theta, c, s);
      step = cell_len >> 1;
      if (step < 3277) step = 3277;
      w = width_cells > GRID_SIDE ? GRID_SIDE : width_cells;
      h = height_cells > GRID_SIDE ? GRID_SIDE : height_cells;
      // March outwards until the ray leaves the map, hits or runs out.
      for (travel = 0; travel <= reach_limit; travel += step) begin
        dx = longint'(r.robot_x) + ((longint'(travel) * c) >>> 30) - corner_x;
        dy = longint'(r.robot_y) + ((longint'(travel) * s) >>> 30) - corner_y;
        if (dx < 0 || dy < 0) begin
          res.status = ST_LEFT;
          return res;
        end
        col = cell_of(dx);
        row = cell_of(dy);
        if (col >= w || row >= h) begin
          res.status = ST_LEFT;
          return res;
        end
        v = grid[row * w + col];
        if (int'(v) >= int'(occ_level)) begin
          res.status = ST_HIT;
          res.column = col[9:0];
          res.row = row[9:0];
          g = corner_x + col * cell_len + (cell_len >> 1);
          res.goal_x = g[31:0];
          g = corner_y + row * cell_len + (cell_len >> 1);
          res.goal_y = g[31:0];
          return res;
        end
      end
      return res;
    endfunction

    function void note_request(ray_request_t r);
      if (r.op == OP_WRITE) begin
        grid[r.cell_index] = r.cell_value;
        loaded = 1;
      end else begin
        owed.push_back(cast_ray(r));
      end
    endfunction

    function void check_result(ray_result_t a);
      ray_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, a.status);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (a.status !== e.status || a.column !== e.column || a.row !== e.row ||
          a.goal_x !== e.goal_x || a.goal_y !== e.goal_y) begin
        $display("%0t: mismatch, expected st %0d col %0d row %0d gx %h gy %h",
                 $time, e.status, e.column, e.row, e.goal_x, e.goal_y);
        $display("%0t:           actual st %0d col %0d row %0d gx %h gy %h",
                 $time, a.status, a.column, a.row, a.goal_x, a.goal_y);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = 1'b0;
  logic [19:0]        cell_index = '0;
  logic signed [7:0]  cell_value = '0;
  logic signed [31:0] robot_x = '0;
  logic signed [31:0] robot_y = '0;
  logic signed [15:0] quat_x = '0;
  logic signed [15:0] quat_y = '0;
  logic signed [15:0] quat_z = '0;
  logic signed [15:0] quat_w = '0;
  logic signed [15:0] bearing = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [9:0]         hit_column;
  logic [9:0]         hit_row;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;

  ray_scoreboard ray_sb = new();
  bit            quiet = 0;
  int            requests_sent = 0;
  int            stall_left = 0;
  int            cycles = 0;
  logic [31:0]   settings [8];

  occupancy_grid_ray_cast_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Result side: check accepted results and stall in short random bursts.
  always @(posedge clk) begin
    ray_result_t got;
    if (out_valid && !out_stall) begin
      got.status = status_t'(status);
      got.column = hit_column;
      got.row = hit_row;
      got.goal_x = goal_x;
      got.goal_y = goal_y;
      ray_sb.check_result(got);
    end
    if (rst || quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one request, possibly after a short gap, and waits for acceptance.
  task automatic send(ray_request_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= r.op;
    cell_index <= r.cell_index;
    cell_value <= r.cell_value;
    robot_x <= r.robot_x;
    robot_y <= r.robot_y;
    quat_x <= r.quat_x;
    quat_y <= r.quat_y;
    quat_z <= r.quat_z;
    quat_w <= r.quat_w;
    bearing <= r.bearing;
    do @(posedge clk); while (in_stall);
    ray_sb.note_request(r);
    requests_sent++;
  endtask

  // Holds the request side until every owed result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (ray_sb.owed.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Writes all eight registers on consecutive cycles.
  task automatic apply_settings();
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= settings[i];
      @(posedge clk);
      ray_sb.set_reg(reg_index_t'(i), settings[i]);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic ray_request_t blank_request();
    ray_request_t r;
    r.op = OP_CAST;
    r.cell_index = '0;
    r.cell_value = '0;
    r.robot_x = '0;
    r.robot_y = '0;
    r.quat_x = '0;
    r.quat_y = '0;
    r.quat_z = '0;
    r.quat_w = 16'sd16384;
    r.bearing = '0;
    return r;
  endfunction

  task automatic write_cell(int idx, int val);
    ray_request_t r;
    r = blank_request();
    r.op = OP_WRITE;
    r.cell_index = idx[19:0];
    r.cell_value = val[7:0];
    send(r);
  endtask

  // Loads every cell of the map in use; some cells are occupied.
  task automatic fill_map();
    int w, h;
    w = ray_sb.width_cells > GRID_SIDE ? GRID_SIDE : ray_sb.width_cells;
    h = ray_sb.height_cells > GRID_SIDE ? GRID_SIDE : ray_sb.height_cells;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 4) == 0) write_cell(i, $urandom_range(ray_sb.occ_level, 127));
      else write_cell(i, $urandom_range(0, 255) - 128);
    end
  endtask

  // A cast from somewhere on the map in a random direction.
  task automatic cast_on_map();
    ray_request_t r;
    longint span_x, span_y, px, py;
    r = blank_request();
    span_x = longint'(ray_sb.width_cells > GRID_SIDE ? GRID_SIDE : ray_sb.width_cells)
             * ray_sb.cell_len;
    span_y = longint'(ray_sb.height_cells > GRID_SIDE ? GRID_SIDE : ray_sb.height_cells)
             * ray_sb.cell_len;
    px = ray_sb.corner_x + longint'($urandom) % (span_x + 1);
    py = ray_sb.corner_y + longint'($urandom) % (span_y + 1);
    r.robot_x = px[31:0];
    r.robot_y = py[31:0];
    if ($urandom_range(0, 3) == 0) begin
      r.quat_x = 16'($urandom_range(0, 8000) - 4000);
      r.quat_y = 16'($urandom_range(0, 8000) - 4000);
    end
    r.quat_z = 16'($urandom_range(0, 32768) - 16384);
    r.quat_w = 16'($urandom_range(0, 32768) - 16384);
    r.bearing = 16'($urandom_range(0, 51472) - 25736);
    send(r);
  endtask

  // A cast with every field random.
  task automatic cast_noise();
    ray_request_t r;
    r = blank_request();
    r.robot_x = $urandom;
    r.robot_y = $urandom;
    r.quat_x = 16'($urandom_range(0, 32768) - 16384);
    r.quat_y = 16'($urandom_range(0, 32768) - 16384);
    r.quat_z = 16'($urandom_range(0, 32768) - 16384);
    r.quat_w = 16'($urandom_range(0, 32768) - 16384);
    r.bearing = 16'($urandom_range(0, 51472) - 25736);
    send(r);
  endtask

  task automatic cast_pose(int rx, int ry, int qx, int qy, int qz, int qw, int b);
    ray_request_t r;
    r = blank_request();
    r.robot_x = rx;
    r.robot_y = ry;
    r.quat_x = qx[15:0];
    r.quat_y = qy[15:0];
    r.quat_z = qz[15:0];
    r.quat_w = qw[15:0];
    r.bearing = b[15:0];
    send(r);
  endtask

  initial begin
    int casts;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Casts before any map is loaded.
    cast_pose(0, 0, 0, 0, 0, 16384, 0);
    cast_pose(65536, 65536, 0, 0, 16384, 0, 25736);

    // 8 x 8 map of 1 m cells centred on the origin.
    settings = '{8, 8, 65536, 65536, -262144, -262144, 1966080, 50};
    apply_settings();
    fill_map();
    // Straight ahead, zero yaw vector, backwards, bearing extremes.
    cast_pose(0, 0, 0, 0, 0, 16384, 0);
    cast_pose(0, 0, 0, 8192, 8192, 0, 0);
    cast_pose(0, 0, 0, 0, 16384, 0, 0);
    cast_pose(0, 0, 0, 0, 16384, 16384, 25736);
    cast_pose(0, 0, 0, 0, -16384, 16384, -25736);
    cast_pose(32768, -32768, 16384, 16384, 16384, -16384, 12000);
    cast_pose(-32768, 32768, -16384, -16384, -16384, -16384, -12000);
    cast_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 16384, 0);
    cast_pose(32'h80000000, 32'h80000000, 0, 0, 0, 16384, 0);

    // One-cell map, finest cells, zero range and level zero.
    settings = '{1, 1, 1, 32'h7FFFFFFF, 0, 0, 0, 0};
    apply_settings();
    write_cell(0, 0);
    cast_pose(0, 0, 0, 0, 0, 16384, 0);
    write_cell(0, -1);
    cast_pose(0, 0, 0, 0, 0, 16384, 0);

    // Oversized width with zero height, then zero width with full height.
    settings = '{2047, 0, 1048576, 0, 0, 0, 16777216, 127};
    apply_settings();
    cast_pose(65536, 65536, 0, 0, 0, 16384, 0);
    settings = '{0, 1024, 1048576, 0, 0, 0, 16777216, 127};
    apply_settings();
    cast_pose(65536, 65536, 0, 0, 0, 16384, 0);

    // Zero inverse cell size: every sample lands in the corner cell.
    settings = '{4, 4, 65536, 0, 0, 0, 65540, 100};
    apply_settings();
    fill_map();
    cast_pose(0, 0, 0, 0, 0, 16384, 0);
    cast_pose(0, 0, 0, 0, 16384, 0, 0);
    cast_pose(655360, 655360, 0, 0, 0, 16384, 3000);

    // Random settings; the last phase runs without idling.
    while (requests_sent < 650) begin
      settings[0] = $urandom_range(1, 12);
      settings[1] = $urandom_range(1, 12);
      settings[2] = $urandom_range(3000, 300000);
      settings[3] = 32'(64'h1_0000_0000 / settings[2]) + $urandom_range(0, 2) - 1;
      settings[4] = $urandom_range(0, 32'h01000000) - 32'h00800000;
      settings[5] = $urandom_range(0, 32'h01000000) - 32'h00800000;
      settings[6] = $urandom_range(0, 40 * 65536);
      settings[7] = $urandom_range(0, 127);
      apply_settings();
      if (requests_sent > 560) quiet = 1;
      fill_map();
      casts = $urandom_range(25, 40);
      for (int i = 0; i < casts; i++) begin
        case ($urandom_range(0, 9))
          0: cast_noise();
          1: write_cell($urandom_range(0, CELLS - 1), $urandom_range(0, 255) - 128);
          default: cast_on_map();
        endcase
      end
    end

    drain();
    if (ray_sb.errors == 0 && ray_sb.owed.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
